/* hw/rtl/ihx_pkg.sv */
package ihx_pkg;

  typedef enum logic [1:0] {
    VERDICT_PASS   = 2'd0,
    VERDICT_DROP   = 2'd1,
    VERDICT_PARSED = 2'd2
  } verdict_e;

  localparam logic [5:0]  OFFSET_MAX           = 6'd63;
  localparam logic [15:0] ETHERTYPE_IPV4       = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP           = 8'd1;
  localparam logic [7:0]  PROTO_TCP            = 8'd6;
  localparam logic [7:0]  PROTO_UDP            = 8'd17;
  localparam logic [7:0]  ICMP_TYPE_ECHO_REPLY = 8'd0;
  localparam logic [7:0]  ICMP_TYPE_ECHO       = 8'd8;
  localparam logic [6:0]  LEN_ETH              = 7'd14;
  localparam logic [6:0]  LEN_IP               = 7'd34;
  localparam logic [6:0]  LEN_TCP              = 7'd54;
  localparam logic [6:0]  LEN_UDP_ICMP         = 7'd42;

  localparam int unsigned OUT_DATA_W = 184;

  // Header record handed from the parser front to the result formatter.
  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [7:0]  flags;
    logic [7:0]  icmp_kind;
  } hdr_rec_t;

endpackage

/* hw/rtl/ihx_front.sv */
module ihx_front import ihx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic     [7:0] byte_i,
  input  logic     last_i,
  output logic     push_o,
  output hdr_rec_t rec_o
);

  logic [5:0]  offset_q, offset_d;
  logic [15:0] ether_q, ether_d, ether_c;
  logic [7:0]  proto_q, proto_d, proto_c;
  logic [31:0] src_q, src_d, src_c;
  logic [31:0] dst_q, dst_d, dst_c;
  logic [31:0] wa_q, wa_d, wa_c;
  logic [31:0] wb_q, wb_d, wb_c;
  logic [31:0] wc_q, wc_d, wc_c;
  logic [7:0]  flags_q, flags_d, flags_c;
  logic [7:0]  kind_q, kind_d, kind_c;
  logic [6:0]  len;
  verdict_e    verdict;

  // Captured header fields including the byte on the bus this cycle.
  always_comb begin
    ether_c = ether_q;
    proto_c = proto_q;
    src_c   = src_q;
    dst_c   = dst_q;
    wa_c    = wa_q;
    wb_c    = wb_q;
    wc_c    = wc_q;
    flags_c = flags_q;
    kind_c  = kind_q;
    if (offset_q == 6'd12 || offset_q == 6'd13) begin
      ether_c = {ether_q[7:0], byte_i};
    end else if (offset_q == 6'd23) begin
      proto_c = byte_i;
    end else if (offset_q >= 6'd26 && offset_q <= 6'd29) begin
      src_c = {src_q[23:0], byte_i};
    end else if (offset_q >= 6'd30 && offset_q <= 6'd33) begin
      dst_c = {dst_q[23:0], byte_i};
    end else if (offset_q >= 6'd34 && offset_q <= 6'd37) begin
      wa_c = {wa_q[23:0], byte_i};
    end else if (offset_q >= 6'd38 && offset_q <= 6'd41) begin
      wb_c = {wb_q[23:0], byte_i};
    end else if (offset_q >= 6'd42 && offset_q <= 6'd45) begin
      wc_c = {wc_q[23:0], byte_i};
    end else if (offset_q == 6'd47) begin
      flags_c = byte_i;
    end
    if (offset_q == 6'd34) begin
      kind_c = byte_i;
    end
  end

  // The marked byte counts toward the frame length.
  assign len = {1'b0, offset_q} + 7'd1;

  always_comb begin
    if (len < LEN_ETH) begin
      verdict = VERDICT_DROP;
    end else if (ether_c != ETHERTYPE_IPV4) begin
      verdict = VERDICT_PASS;
    end else if (len < LEN_IP ||
                 (proto_c == PROTO_TCP && len < LEN_TCP) ||
                 ((proto_c == PROTO_UDP || proto_c == PROTO_ICMP) &&
                  len < LEN_UDP_ICMP)) begin
      verdict = VERDICT_DROP;
    end else begin
      verdict = VERDICT_PARSED;
    end
  end

  always_comb begin
    rec_o.verdict   = verdict;
    rec_o.proto     = proto_c;
    rec_o.src_ip    = src_c;
    rec_o.dst_ip    = dst_c;
    rec_o.word_a    = wa_c;
    rec_o.word_b    = wb_c;
    rec_o.word_c    = wc_c;
    rec_o.flags     = flags_c;
    rec_o.icmp_kind = kind_c;
    push_o          = accept_i && last_i;
  end

  // Everything returns to zero after the last byte of a frame.
  always_comb begin
    offset_d = offset_q;
    ether_d  = ether_q;
    proto_d  = proto_q;
    src_d    = src_q;
    dst_d    = dst_q;
    wa_d     = wa_q;
    wb_d     = wb_q;
    wc_d     = wc_q;
    flags_d  = flags_q;
    kind_d   = kind_q;
    if (accept_i) begin
      if (last_i) begin
        offset_d = '0;
        ether_d  = '0;
        proto_d  = '0;
        src_d    = '0;
        dst_d    = '0;
        wa_d     = '0;
        wb_d     = '0;
        wc_d     = '0;
        flags_d  = '0;
        kind_d   = '0;
      end else begin
        offset_d = (offset_q == OFFSET_MAX) ? OFFSET_MAX : offset_q + 6'd1;
        ether_d  = ether_c;
        proto_d  = proto_c;
        src_d    = src_c;
        dst_d    = dst_c;
        wa_d     = wa_c;
        wb_d     = wb_c;
        wc_d     = wc_c;
        flags_d  = flags_c;
        kind_d   = kind_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      ether_q  <= '0;
      proto_q  <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      wa_q     <= '0;
      wb_q     <= '0;
      wc_q     <= '0;
      flags_q  <= '0;
      kind_q   <= '0;
    end else begin
      offset_q <= offset_d;
      ether_q  <= ether_d;
      proto_q  <= proto_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      wa_q     <= wa_d;
      wb_q     <= wb_d;
      wc_q     <= wc_d;
      flags_q  <= flags_d;
      kind_q   <= kind_d;
    end
  end

  a_offset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_i) |=> (offset_q == '0 && ether_q == '0))
    else $error("offset not cleared after last item of a frame");

  a_offset_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !last_i && offset_q == OFFSET_MAX) |=> (offset_q == OFFSET_MAX))
    else $error("byte offset did not saturate");

endmodule

/* hw/rtl/ihx_queue.sv */
module ihx_queue import ihx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hdr_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     avail_o,
  output hdr_rec_t rec_o
);

  hdr_rec_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("item pushed into a full queue");

endmodule

/* hw/rtl/ihx_back.sv */
module ihx_back import ihx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  avail_i,
  input  hdr_rec_t              rec_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic                  valid_q, valid_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic                  load;
  logic [15:0]           src_port, dst_port;
  logic [31:0]           seq, ack, sip, dip;
  logic [7:0]            flags, proto;

  assign load  = avail_i && (!valid_q || m_axis_tready_i);
  assign pop_o = load;

  // Fields a protocol does not define come out as zero.
  always_comb begin
    src_port = '0;
    dst_port = '0;
    seq      = '0;
    ack      = '0;
    flags    = '0;
    sip      = '0;
    dip      = '0;
    proto    = '0;
    if (rec_i.verdict == VERDICT_PARSED) begin
      sip   = rec_i.src_ip;
      dip   = rec_i.dst_ip;
      proto = rec_i.proto;
      if (rec_i.proto == PROTO_TCP) begin
        src_port = rec_i.word_a[31:16];
        dst_port = rec_i.word_a[15:0];
        seq      = rec_i.word_b;
        ack      = rec_i.word_c;
        flags    = rec_i.flags;
      end else if (rec_i.proto == PROTO_UDP) begin
        src_port = rec_i.word_a[31:16];
        dst_port = rec_i.word_a[15:0];
      end else if (rec_i.proto == PROTO_ICMP) begin
        if (rec_i.icmp_kind == ICMP_TYPE_ECHO ||
            rec_i.icmp_kind == ICMP_TYPE_ECHO_REPLY) begin
          src_port = rec_i.word_b[31:16];
        end
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = {6'b0, flags, ack, seq, dst_port, src_port, proto, dip, sip,
                 rec_i.verdict};
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

  a_zero_unparsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && data_q[1:0] != VERDICT_PARSED) |-> (data_q[177:2] == '0))
    else $error("non-parsed result carries nonzero fields");

endmodule

/* hw/rtl/eth_ipv4_l4_header_extract_core.sv */
// A frame's result is written into the record queue when its last item is accepted,
// then loaded into the output register that drives tvalid. Throughput: one frame byte
// per cycle while the queue is not full; a result can leave every cycle.
// A two-entry record queue between the byte parser and the output register
// absorbs output stalls; input stalls only when that queue is full.
// Reset (rst_ni low, asynchronous) clears the byte offset, captured fields,
// queue and output valid; the block is ready right after reset.
module eth_ipv4_l4_header_extract_core import ihx_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] frame_byte
  input  logic                  s_axis_tlast,   // last_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] verdict, [33:2] src_ip, [65:34] dst_ip, [73:66] ip_proto,
  // [89:74] src_port, [105:90] dst_port, [137:106] tcp_seq,
  // [169:138] tcp_ack, [177:170] tcp_flags, [183:178] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic     accept, push, full, avail, pop;
  hdr_rec_t rec_in, rec_out;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  ihx_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  ihx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .rec_o   (rec_out)
  );

  ihx_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .rec_i           (rec_out),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

/* verif/eth_ipv4_l4_header_extract_core_test.sv */
module eth_ipv4_l4_header_extract_core_test;
  import ihx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_BYTES    = 110;
  localparam int RANDOM_FRAMES   = 2;

  localparam logic [15:0] ETYPE_IPV6        = 16'h86DD;
  localparam logic [7:0]  PROTO_GRE         = 8'd47;
  localparam logic [7:0]  ICMP_TYPE_UNREACH = 8'd3;

  typedef enum logic [1:0] {
    FILL_RANDOM = 2'd0,
    FILL_ZEROS  = 2'd1,
    FILL_ONES   = 2'd2
  } fill_e;

  // Same layout as m_axis_tdata, highest field first.
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  tcp_flags;
    logic [31:0] tcp_ack;
    logic [31:0] tcp_seq;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [7:0]  ip_proto;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    verdict_e    verdict;
  } hdr_result_t;

  typedef struct packed {
    logic [7:0]  len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [7:0]  l4_type;
    fill_e       fill;
    logic        typed;
    verdict_e    verdict;
  } frame_case_t;

  // Rows with typed set carry their verdict; all other result fields are zero there.
  localparam frame_case_t DIR_CASES [22] = '{
    '{8'd1,   ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd13,  ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd13,  ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_ONES,   1'b1, VERDICT_DROP},
    '{8'd14,  ETYPE_IPV6,     PROTO_TCP,  8'd0, FILL_RANDOM, 1'b1, VERDICT_PASS},
    '{8'd14,  ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd33,  ETHERTYPE_IPV4, PROTO_GRE,  8'd0, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd34,  ETHERTYPE_IPV4, PROTO_GRE,  8'd0, FILL_RANDOM, 1'b0, VERDICT_PARSED},
    '{8'd53,  ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_RANDOM, 1'b0, VERDICT_PARSED},
    '{8'd41,  ETHERTYPE_IPV4, PROTO_UDP,  8'd0, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd42,  ETHERTYPE_IPV4, PROTO_UDP,  8'd0, FILL_RANDOM, 1'b0, VERDICT_PARSED},
    '{8'd41,  ETHERTYPE_IPV4, PROTO_ICMP, ICMP_TYPE_ECHO, FILL_RANDOM, 1'b1, VERDICT_DROP},
    '{8'd42,  ETHERTYPE_IPV4, PROTO_ICMP, ICMP_TYPE_ECHO, FILL_RANDOM, 1'b0, VERDICT_PARSED},
    '{8'd42,  ETHERTYPE_IPV4, PROTO_ICMP, ICMP_TYPE_ECHO_REPLY, FILL_RANDOM, 1'b0,
      VERDICT_PARSED},
    '{8'd60,  ETHERTYPE_IPV4, PROTO_ICMP, ICMP_TYPE_UNREACH, FILL_RANDOM, 1'b0,
      VERDICT_PARSED},
    '{8'd66,  ETHERTYPE_IPV4, PROTO_TCP,  8'd0, FILL_RANDOM, 1'b0, VERDICT_PARSED},
    '{8'd72,  ETHERTYPE_IPV4, PROTO_UDP,  8'd0, FILL_RANDOM, 1'b0, VERDICT_PARSED},
    '{8'd64,  16'hFFFF,       8'hFF,      8'hFF, FILL_ONES,  1'b1, VERDICT_PASS},
    '{8'd64,  16'h0000,       8'h00,      8'h00, FILL_ZEROS, 1'b1, VERDICT_PASS},
    '{8'd64,  ETHERTYPE_IPV4, 8'hFF,      8'hFF, FILL_ONES,  1'b0, VERDICT_PARSED},
    '{8'd34,  ETHERTYPE_IPV4, 8'h00,      8'h00, FILL_ZEROS, 1'b0, VERDICT_PARSED},
    '{8'd54,  ETHERTYPE_IPV4, PROTO_TCP,  8'hFF, FILL_ONES,  1'b0, VERDICT_PARSED}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  eth_ipv4_l4_header_extract_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Header capture state mirrored from the block.
  logic [5:0]  hdr_offset;
  logic [15:0] hdr_etype;
  logic [7:0]  hdr_proto;
  logic [31:0] hdr_src;
  logic [31:0] hdr_dst;
  logic [31:0] l4_a;
  logic [31:0] l4_b;
  logic [31:0] l4_c;
  logic [7:0]  hdr_flags;
  logic [7:0]  hdr_icmp_type;

  hdr_result_t pending_hdrs [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          src_rush = 1'b0;
  bit          hold_req = 1'b0;
  int          rx_gap_max = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void clear_hdr_state();
    hdr_offset    = '0;
    hdr_etype     = '0;
    hdr_proto     = '0;
    hdr_src       = '0;
    hdr_dst       = '0;
    l4_a          = '0;
    l4_b          = '0;
    l4_c          = '0;
    hdr_flags     = '0;
    hdr_icmp_type = '0;
  endfunction

  // Takes one accepted byte; returns 1 with the frame's result on the last byte.
  function automatic bit parse_hdr_byte(input logic [7:0] b, input logic last,
                                        output hdr_result_t res);
    logic [5:0] pos;
    logic [6:0] len;
    pos = hdr_offset;
    res = '0;
    if (pos == 6'd12 || pos == 6'd13) hdr_etype = {hdr_etype[7:0], b};
    else if (pos == 6'd23) hdr_proto = b;
    else if (pos >= 6'd26 && pos <= 6'd29) hdr_src = {hdr_src[23:0], b};
    else if (pos >= 6'd30 && pos <= 6'd33) hdr_dst = {hdr_dst[23:0], b};
    else if (pos >= 6'd34 && pos <= 6'd37) l4_a = {l4_a[23:0], b};
    else if (pos >= 6'd38 && pos <= 6'd41) l4_b = {l4_b[23:0], b};
    else if (pos >= 6'd42 && pos <= 6'd45) l4_c = {l4_c[23:0], b};
    else if (pos == 6'd47) hdr_flags = b;
    if (pos == 6'd34) hdr_icmp_type = b;
    if (hdr_offset != OFFSET_MAX) hdr_offset = hdr_offset + 6'd1;
    if (!last) return 1'b0;

    len = {1'b0, pos} + 7'd1;
    if (len < LEN_ETH) begin
      res.verdict = VERDICT_DROP;
    end else if (hdr_etype != ETHERTYPE_IPV4) begin
      res.verdict = VERDICT_PASS;
    end else if (len < LEN_IP || (hdr_proto == PROTO_TCP && len < LEN_TCP) ||
                 ((hdr_proto == PROTO_UDP || hdr_proto == PROTO_ICMP) &&
                  len < LEN_UDP_ICMP)) begin
      res.verdict = VERDICT_DROP;
    end else begin
      res.verdict  = VERDICT_PARSED;
      res.src_ip   = hdr_src;
      res.dst_ip   = hdr_dst;
      res.ip_proto = hdr_proto;
      if (hdr_proto == PROTO_TCP) begin
        res.src_port  = l4_a[31:16];
        res.dst_port  = l4_a[15:0];
        res.tcp_seq   = l4_b;
        res.tcp_ack   = l4_c;
        res.tcp_flags = hdr_flags;
      end else if (hdr_proto == PROTO_UDP) begin
        res.src_port = l4_a[31:16];
        res.dst_port = l4_a[15:0];
      end else if (hdr_proto == PROTO_ICMP) begin
        // The echo id sits in the upper half of the second layer-4 word.
        if (hdr_icmp_type == ICMP_TYPE_ECHO || hdr_icmp_type == ICMP_TYPE_ECHO_REPLY) begin
          res.src_port = l4_b[31:16];
        end
      end
    end
    clear_hdr_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got,
               want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    hdr_result_t got;
    hdr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = hdr_result_t'(m_axis_tdata);
      results_seen++;
      if (pending_hdrs.size() == 0) begin
        report_mismatch("unexpected result verdict", 32'(got.verdict), 32'd0);
      end else begin
        want = pending_hdrs.pop_front();
        check_field("verdict", 32'(got.verdict), 32'(want.verdict));
        check_field("src_ip", got.src_ip, want.src_ip);
        check_field("dst_ip", got.dst_ip, want.dst_ip);
        check_field("ip_proto", 32'(got.ip_proto), 32'(want.ip_proto));
        check_field("src_port", 32'(got.src_port), 32'(want.src_port));
        check_field("dst_port", 32'(got.dst_port), 32'(want.dst_port));
        check_field("tcp_seq", got.tcp_seq, want.tcp_seq);
        check_field("tcp_ack", got.tcp_ack, want.tcp_ack);
        check_field("tcp_flags", 32'(got.tcp_flags), 32'(want.tcp_flags));
        check_field("padding", 32'(got.pad), 32'd0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall after each item, plus one long hold-off on request.
  initial begin
    int stall;
    int taken;
    taken = 0;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        taken++;
        if (taken % 16 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
        stall = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_frame(input int len, input logic [15:0] etype,
                            input logic [7:0] proto, input logic [7:0] l4_type,
                            input fill_e fill, input bit typed, input verdict_e verdict);
    logic [7:0]  frame [256];
    hdr_result_t res;
    bit          done;
    int          gap_max;
    int          gap;
    for (int i = 0; i < 256; i++) begin
      case (fill)
        FILL_ZEROS: frame[i] = 8'h00;
        FILL_ONES:  frame[i] = 8'hFF;
        default:    frame[i] = 8'($urandom_range(0, 255));
      endcase
    end
    frame[12] = etype[15:8];
    frame[13] = etype[7:0];
    frame[23] = proto;
    if (proto == PROTO_ICMP) frame[34] = l4_type;
    gap_max = (src_rush || $urandom_range(0, 9) < 3) ? 0 : 19;
    for (int i = 0; i < len; i++) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame[i];
      s_axis_tlast  <= (i == len - 1);
      do @(posedge clk_i); while (!s_axis_tready);
      done = parse_hdr_byte(frame[i], i == len - 1, res);
      if (done) begin
        if (typed) begin
          res         = '0;
          res.verdict = verdict;
        end
        pending_hdrs.push_back(res);
      end
      bytes_sent++;
    end
    frames_sent++;
  endtask

  task automatic send_random_frame();
    int          kind;
    int          len;
    int          min_len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [7:0]  l4_type;
    fill_e       fill;
    kind  = $urandom_range(0, 99);
    etype = ETHERTYPE_IPV4;
    case ($urandom_range(0, 4))
      0:       proto = PROTO_TCP;
      1:       proto = PROTO_UDP;
      2, 3:    proto = PROTO_ICMP;
      default: proto = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 2))
      0:       l4_type = ICMP_TYPE_ECHO;
      1:       l4_type = ICMP_TYPE_ECHO_REPLY;
      default: l4_type = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 19))
      0:       fill = FILL_ZEROS;
      1:       fill = FILL_ONES;
      default: fill = FILL_RANDOM;
    endcase
    if (proto == PROTO_TCP) min_len = int'(LEN_TCP);
    else if (proto == PROTO_UDP || proto == PROTO_ICMP) min_len = int'(LEN_UDP_ICMP);
    else min_len = int'(LEN_IP);

    if (kind < 15) begin
      // Runts and noise.
      len   = $urandom_range(1, 20);
      etype = 16'($urandom_range(0, 65535));
    end else if (kind < 25) begin
      len   = $urandom_range(14, 80);
      etype = 16'($urandom_range(0, 65535));
    end else if (kind < 40) begin
      // Right at a length threshold or one byte short of it.
      len = min_len - $urandom_range(0, 1);
    end else if (kind < 92) begin
      len = $urandom_range(min_len, 64);
    end else begin
      len = $urandom_range(65, 150);
    end
    send_frame(len, etype, proto, l4_type, fill, 1'b0, VERDICT_PARSED);
  endtask

  // The input goes idle first so the last byte is not offered again.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    do @(posedge clk_i); while (pending_hdrs.size() != 0);
  endtask

  initial begin
    frame_case_t row;
    int          start_bytes;
    int          start_frames;
    clear_hdr_state();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(DIR_CASES); i++) begin
      row = DIR_CASES[i];
      send_frame(int'(row.len), row.etype, row.proto, row.l4_type, row.fill, row.typed,
                 row.verdict);
    end
    wait_results_drained();

    // Back-pressure: short frames pile up behind a held output until the input stalls.
    src_rush = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_frame($urandom_range(1, 3), ETHERTYPE_IPV4, PROTO_TCP, 8'd0, FILL_RANDOM, 1'b0,
                 VERDICT_PARSED);
    end
    src_rush = 1'b0;
    wait_results_drained();

    start_bytes  = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES ||
           frames_sent - start_frames < RANDOM_FRAMES) begin
      send_random_frame();
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_hdrs.size() != 0) begin
      report_mismatch("results still missing", 32'(pending_hdrs.size()), 32'd0);
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
